@@ hw/rtl/sof_frame_decoder_xor_check_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame decoder checkers.
// ----------------------------------------------------------------------------
`ifndef SOF_FRAME_DECODER_XOR_CHECK_MACROS_SVH
`define SOF_FRAME_DECODER_XOR_CHECK_MACROS_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define SFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sfd assertion failed");

// Antecedent implies consequent in the next cycle, outside reset.
`define SFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sfd assertion failed");

// Antecedent implies consequent in the next cycle, checked during reset too.
`define SFD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sfd assertion failed");

`endif

@@ hw/rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants of the start-of-frame decoder with XOR checksum.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [7:0] START_BYTE = 8'hFE;

    localparam int unsigned OUT_TDATA_W = 64;

    localparam logic RESULT_PAYLOAD   = 1'b0;
    localparam logic RESULT_FRAME_END = 1'b1;

    typedef enum logic [2:0] {
        ST_WAIT    = 3'd0,
        ST_FUNC_HI = 3'd1,
        ST_FUNC_LO = 3'd2,
        ST_LEN_HI  = 3'd3,
        ST_LEN_LO  = 3'd4,
        ST_PAYLOAD = 3'd5,
        ST_CHECK   = 3'd6
    } parse_state_t;

endpackage

@@ hw/rtl/sof_frame_decoder_xor_check.sv @@
// ----------------------------------------------------------------------------
// sof_frame_decoder_xor_check
// Byte stream frame decoder: start byte, function code, length, payload and
// XOR checksum, with one result per payload byte and one per frame end.
// ----------------------------------------------------------------------------
// One byte is taken per cycle at full rate. A byte is held in the input
// register, where the parser updates its state and, for payload and checksum
// bytes, writes the result register, from which the result is presented on
// the master side. Throughput is set only by the result register handshake:
// while m_tready stays high the block takes a byte every cycle; a stalled
// result holds the input register and, one byte later, s_tready.
module sof_frame_decoder_xor_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [sfd_pkg::OUT_TDATA_W-1:0] m_tdata,
    // [7:0] payload_byte, [23:8] payload_index, [39:24] function_code,
    // [55:40] payload_length, [56] checksum_ok, [63:57] zero
    output logic        m_tuser    // [0] result_kind
);

    logic                  in_valid_reg;
    logic [7:0]            in_data_reg;
    sfd_pkg::parse_state_t state_reg, state_next;
    logic [15:0]           function_reg, function_next;
    logic [15:0]           length_reg, length_next;
    logic [15:0]           count_reg, count_next;
    logic [7:0]            xor_reg, xor_next;
    logic                  m_valid_reg;
    logic                  m_kind_reg, m_kind_next;
    logic [7:0]            m_byte_reg, m_byte_next;
    logic [15:0]           m_index_reg, m_index_next;
    logic [15:0]           m_func_reg;
    logic [15:0]           m_len_reg;
    logic                  m_ok_reg, m_ok_next;
    logic                  emit;
    logic                  advance;
    logic                  step;
    logic [15:0]           count_inc;

    assign advance   = !m_valid_reg || m_tready;
    assign step      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign count_inc = count_reg + 16'd1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sfd_pkg::ST_WAIT: begin
                if (in_data_reg == sfd_pkg::START_BYTE) begin
                    state_next = sfd_pkg::ST_FUNC_HI;
                end
            end
            sfd_pkg::ST_FUNC_HI: state_next = sfd_pkg::ST_FUNC_LO;
            sfd_pkg::ST_FUNC_LO: state_next = sfd_pkg::ST_LEN_HI;
            sfd_pkg::ST_LEN_HI:  state_next = sfd_pkg::ST_LEN_LO;
            sfd_pkg::ST_LEN_LO: begin
                if ({length_reg[15:8], in_data_reg} == 16'd0) begin
                    state_next = sfd_pkg::ST_CHECK;
                end else begin
                    state_next = sfd_pkg::ST_PAYLOAD;
                end
            end
            sfd_pkg::ST_PAYLOAD: begin
                if (count_inc >= length_reg || count_inc == 16'd0) begin
                    state_next = sfd_pkg::ST_CHECK;
                end
            end
            sfd_pkg::ST_CHECK: state_next = sfd_pkg::ST_WAIT;
            default:           state_next = sfd_pkg::ST_WAIT;
        endcase
    end

    always_comb begin
        function_next = function_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;
        emit          = 1'b0;
        m_kind_next   = sfd_pkg::RESULT_PAYLOAD;
        m_byte_next   = 8'd0;
        m_index_next  = 16'd0;
        m_ok_next     = 1'b0;
        unique case (state_reg)
            sfd_pkg::ST_WAIT: begin
                if (in_data_reg == sfd_pkg::START_BYTE) begin
                    xor_next = sfd_pkg::START_BYTE;
                end
            end
            sfd_pkg::ST_FUNC_HI: begin
                function_next = {in_data_reg, 8'd0};
                xor_next      = xor_reg ^ in_data_reg;
            end
            sfd_pkg::ST_FUNC_LO: begin
                function_next = {function_reg[15:8], in_data_reg};
                xor_next      = xor_reg ^ in_data_reg;
            end
            sfd_pkg::ST_LEN_HI: begin
                length_next = {in_data_reg, 8'd0};
                xor_next    = xor_reg ^ in_data_reg;
            end
            sfd_pkg::ST_LEN_LO: begin
                length_next = {length_reg[15:8], in_data_reg};
                xor_next    = xor_reg ^ in_data_reg;
                count_next  = 16'd0;
            end
            sfd_pkg::ST_PAYLOAD: begin
                emit         = 1'b1;
                m_byte_next  = in_data_reg;
                m_index_next = count_reg;
                xor_next     = xor_reg ^ in_data_reg;
                count_next   = count_inc;
            end
            sfd_pkg::ST_CHECK: begin
                emit        = 1'b1;
                m_kind_next = sfd_pkg::RESULT_FRAME_END;
                m_ok_next   = (in_data_reg == xor_reg);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= sfd_pkg::ST_WAIT;
            function_reg <= 16'd0;
            length_reg   <= 16'd0;
            count_reg    <= 16'd0;
            xor_reg      <= 8'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step) begin
                state_reg    <= state_next;
                function_reg <= function_next;
                length_reg   <= length_next;
                count_reg    <= count_next;
                xor_reg      <= xor_next;
            end
            if (advance) begin
                m_valid_reg <= step && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (step && emit) begin
            m_kind_reg  <= m_kind_next;
            m_byte_reg  <= m_byte_next;
            m_index_reg <= m_index_next;
            m_func_reg  <= function_next;
            m_len_reg   <= length_next;
            m_ok_reg    <= m_ok_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {7'd0, m_ok_reg, m_len_reg, m_func_reg, m_index_reg, m_byte_reg};

endmodule

@@ hw/rtl/sfd_checker.sv @@
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level assertions for the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "sof_frame_decoder_xor_check_macros.svh"

module sfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [sfd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic        m_tuser
);

    `SFD_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    `SFD_ASSERT_NOW(a_frame_end_fields, aclk, aresetn,
        m_tvalid && (m_tuser == sfd_pkg::RESULT_FRAME_END),
        (m_tdata[23:0] == 24'd0) && (m_tdata[63:57] == 7'd0))

    `SFD_ASSERT_NOW(a_payload_fields, aclk, aresetn,
        m_tvalid && (m_tuser == sfd_pkg::RESULT_PAYLOAD),
        m_tdata[63:56] == 8'd0)

    `SFD_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_tvalid && s_tready)

endmodule

bind sof_frame_decoder_xor_check sfd_checker u_sfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
